// ===== hw/rtl/priority_interrupt_controller_assert.svh =====
// ----------------------------------------------------------------------------
// priority interrupt controller assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PIC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// shared sizes, token format and control types of the interrupt controller
// ----------------------------------------------------------------------------
package pic_pkg;

  // line count and priority width
  localparam int NUM_LINES = 64;
  localparam int PRIO_W    = 8;
  localparam int LINE_W    = $clog2(NUM_LINES);

  // field widths fixed by the bus map and the item format
  localparam int WORD_W  = 3;
  localparam int FIRST_W = 6;
  localparam int CNT_W   = 3;
  localparam int DATA_W  = 32;
  localparam int LNUM_W  = 6;
  localparam int SEL_W   = 6;

  // width for the signed distance between a cell and the first priority byte
  localparam int CMP_W = ((LINE_W > FIRST_W) ? LINE_W : FIRST_W) + 1;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // action carried by a token down the cell chain
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_RD_EN,
    ACT_RD_PEND,
    ACT_RD_PRIO,
    ACT_SET_EN,
    ACT_CLR_EN,
    ACT_SET_PEND,
    ACT_CLR_PEND,
    ACT_WR_PRIO,
    ACT_RAISE,
    ACT_LOWER
  } act_t;

  // token handed from cell to cell
  typedef struct packed {
    act_t                act;
    logic [WORD_W-1:0]   word;
    logic [FIRST_W-1:0]  first;
    logic [CNT_W-1:0]    cnt;
    logic [DATA_W-1:0]   data;
    logic [LNUM_W-1:0]   line;
    logic [DATA_W-1:0]   rd;
    logic                found;
    logic [PRIO_W-1:0]   best_prio;
    logic [LINE_W-1:0]   best_idx;
  } tok_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // controller status seen by the top level
  typedef struct packed {
    logic busy;
    logic hold_v;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/pic_cell.sv =====
// ----------------------------------------------------------------------------
// pic_cell
// one interrupt line: enable, pending and priority, plus one chain stage
// ----------------------------------------------------------------------------
module pic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pic_pkg::LINE_W-1:0]  cell_idx,
  input  logic                        tok_vld_i,
  input  pic_pkg::tok_t               tok_i,
  output logic                        tok_vld_o,
  output pic_pkg::tok_t               tok_o
);
  import pic_pkg::*;

  logic              en_r, en_nxt;
  logic              pend_r, pend_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              tok_vld_r;
  tok_t              tok_r, tok_nxt;

  logic              word_hit;
  logic [4:0]        bitpos;
  logic              dbit;
  logic [CMP_W-1:0]  diff;
  logic              lane_ok;
  logic              wr_ok;
  logic [1:0]        lane;
  logic [7:0]        wbyte;
  logic              line_hit;

  // position of this line relative to the token's fields
  assign word_hit = (tok_i.word == WORD_W'(cell_idx >> 5));
  assign bitpos   = cell_idx[4:0];
  assign dbit     = tok_i.data[bitpos];
  assign diff     = CMP_W'(cell_idx) - CMP_W'(tok_i.first);
  assign lane_ok  = !diff[CMP_W-1] && (diff < CMP_W'(4));
  assign wr_ok    = !diff[CMP_W-1] && (diff < CMP_W'(tok_i.cnt));
  assign lane     = diff[1:0];
  assign wbyte    = tok_i.data[{lane, 3'b000} +: 8];
  assign line_hit = (CMP_W'(tok_i.line) == CMP_W'(cell_idx));

  // apply the token's action, then fold this line into the running best
  always_comb begin
    en_nxt   = en_r;
    pend_nxt = pend_r;
    prio_nxt = prio_r;
    tok_nxt  = tok_i;
    case (tok_i.act)
      ACT_RD_EN:    if (word_hit) tok_nxt.rd[bitpos] = en_r;
      ACT_RD_PEND:  if (word_hit) tok_nxt.rd[bitpos] = pend_r;
      ACT_RD_PRIO:  if (lane_ok) tok_nxt.rd[{lane, 3'b000} +: PRIO_W] = prio_r;
      ACT_SET_EN:   if (word_hit && dbit) en_nxt = 1'b1;
      ACT_CLR_EN:   if (word_hit && dbit) en_nxt = 1'b0;
      ACT_SET_PEND: if (word_hit && dbit) pend_nxt = 1'b1;
      ACT_CLR_PEND: if (word_hit && dbit) pend_nxt = 1'b0;
      ACT_WR_PRIO:  if (wr_ok) prio_nxt = wbyte[PRIO_W-1:0];
      ACT_RAISE:    if (line_hit) pend_nxt = 1'b1;
      ACT_LOWER:    if (line_hit) pend_nxt = 1'b0;
      default: ;
    endcase
    // strict compare keeps the lower line on equal priority
    if (en_nxt && pend_nxt && (!tok_i.found || (prio_nxt < tok_i.best_prio))) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_prio = prio_nxt;
      tok_nxt.best_idx  = cell_idx;
    end
  end

  // line state, updated only while a token passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      pend_r <= 1'b0;
      prio_r <= '0;
    end else if (tok_vld_i) begin
      en_r   <= en_nxt;
      pend_r <= pend_nxt;
      prio_r <= prio_nxt;
    end
  end

  // chain stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld_i) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;

endmodule

// ===== hw/rtl/pic_ctrl.sv =====
// ----------------------------------------------------------------------------
// pic_ctrl
// decodes a transaction into a chain token and collects the chain's result
// ----------------------------------------------------------------------------
module pic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [55:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic [0:0]        out_tuser,
  // chain head and tail
  output logic              launch_vld_o,
  output pic_pkg::tok_t     launch_tok_o,
  input  logic              exit_vld_i,
  input  pic_pkg::tok_t     exit_tok_i,
  // status
  output pic_pkg::ctrl_sts_t sts_o
);
  import pic_pkg::*;

  // bus windows
  localparam logic [11:0] RD_EN_HI    = 12'h01C;
  localparam logic [11:0] RD_PEND_LO  = 12'h020;
  localparam logic [11:0] RD_PEND_HI  = 12'h03C;
  localparam logic [11:0] PRIO_LO     = 12'h400;
  localparam logic [11:0] PRIO_HI     = 12'h43C;
  localparam logic [11:0] SET_EN_LO   = 12'h100;
  localparam logic [11:0] SET_EN_HI   = 12'h11C;
  localparam logic [11:0] CLR_EN_LO   = 12'h180;
  localparam logic [11:0] CLR_EN_HI   = 12'h19C;
  localparam logic [11:0] SET_PEND_LO = 12'h200;
  localparam logic [11:0] SET_PEND_HI = 12'h21C;
  localparam logic [11:0] CLR_PEND_LO = 12'h280;
  localparam logic [11:0] CLR_PEND_HI = 12'h29C;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic              status;
    logic              irq;
    logic [SEL_W-1:0]  sel;
  } res_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
    logic [DATA_W-1:0] m;
    case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  state_t            state_r, state_nxt;
  logic              in_fire;
  logic [1:0]        opcode;
  logic [11:0]       off;
  logic [DATA_W-1:0] wdata;
  logic [CNT_W-1:0]  cnt_raw;
  logic [CNT_W-1:0]  cnt_c;
  logic [LNUM_W-1:0] line;
  tok_t              dec_tok;
  logic              dec_status;
  logic              launch_vld_r;
  tok_t              launch_tok_r;
  logic              status_r;
  res_t              res;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;
  logic              hold_v_r, hold_v_nxt;
  res_t              hold_r, hold_nxt;

  // input fields
  assign opcode  = in_tuser;
  assign off     = in_tdata[11:0];
  assign wdata   = in_tdata[43:12];
  assign cnt_raw = in_tdata[46:44];
  assign line    = in_tdata[52:47];
  assign cnt_c   = (cnt_raw > 3'd4) ? 3'd4 : cnt_raw;
  assign in_fire = in_tvalid && in_tready;

  // state machine: one token in the chain at a time
  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE) && !hold_v_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_BUSY;
      ST_BUSY: if (exit_vld_i) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // transaction decode
  always_comb begin
    dec_tok           = '0;
    dec_tok.act       = ACT_NONE;
    dec_tok.word      = off[4:2];
    dec_tok.first     = off[5:0];
    dec_tok.cnt       = cnt_c;
    dec_tok.data      = wdata & byte_mask(cnt_c);
    dec_tok.line      = line;
    dec_status        = 1'b0;
    unique case (opcode)
      OP_READ: begin
        if (off <= RD_EN_HI) dec_tok.act = ACT_RD_EN;
        else if (off >= RD_PEND_LO && off <= RD_PEND_HI) dec_tok.act = ACT_RD_PEND;
        else if (off >= PRIO_LO && off <= PRIO_HI) dec_tok.act = ACT_RD_PRIO;
        else dec_status = 1'b1;
      end
      OP_WRITE: begin
        if (off >= SET_EN_LO && off <= SET_EN_HI) dec_tok.act = ACT_SET_EN;
        else if (off >= CLR_EN_LO && off <= CLR_EN_HI) dec_tok.act = ACT_CLR_EN;
        else if (off >= SET_PEND_LO && off <= SET_PEND_HI) dec_tok.act = ACT_SET_PEND;
        else if (off >= CLR_PEND_LO && off <= CLR_PEND_HI) dec_tok.act = ACT_CLR_PEND;
        else if (off >= PRIO_LO && off <= PRIO_HI) dec_tok.act = ACT_WR_PRIO;
        else dec_status = 1'b1;
      end
      OP_RAISE: dec_tok.act = ACT_RAISE;
      OP_CLEAR: dec_tok.act = ACT_LOWER;
      default:  dec_tok.act = ACT_NONE;
    endcase
  end

  // launch register feeding the first cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_vld_r <= 1'b0;
    end else begin
      launch_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      launch_tok_r <= dec_tok;
      status_r     <= dec_status;
    end
  end

  assign launch_vld_o = launch_vld_r;
  assign launch_tok_o = launch_tok_r;

  // result from the chain tail
  always_comb begin
    res.rd     = exit_tok_i.rd & byte_mask(exit_tok_i.cnt);
    res.status = status_r;
    res.irq    = exit_tok_i.found;
    res.sel    = exit_tok_i.found ? SEL_W'(exit_tok_i.best_idx) : '0;
  end

  // output register with a hold slot behind it
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (out_v_r && out_tready) begin
      out_v_nxt  = hold_v_r;
      out_nxt    = hold_r;
      hold_v_nxt = 1'b0;
    end
    if (exit_vld_i) begin
      if (!out_v_nxt) begin
        out_v_nxt = 1'b1;
        out_nxt   = res;
      end else begin
        hold_v_nxt = 1'b1;
        hold_nxt   = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = {1'b0, out_r.sel, out_r.irq, out_r.rd};
  assign out_tuser    = out_r.status;
  assign sts_o.busy   = (state_r == ST_BUSY);
  assign sts_o.hold_v = hold_v_r;

endmodule

// ===== hw/rtl/priority_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// priority_interrupt_controller
// interrupt controller with per-line enable, pending and priority in a chain
// of line cells; every transaction reports the best enabled pending line
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                          | payload
//  --------+-----------+--------------------------------+--------------------------
//  in      | slave     | in_tvalid/in_tready/tdata/tuser | bus access or line event
//  out     | master    | out_tvalid/out_tready/tdata/tuser | read data and winner
//
// the result passes the launch register, which loads on the accepting edge,
// then the 64 line cells in chain order, then the output register; the next
// transaction is accepted only once the token has left the chain, so the
// block takes one transaction at a time, while the previous result may still wait.
// synchronous active-low reset clears all enables, pending bits, priorities.
// a stalled output keeps its result; a second result waits in a hold slot,
// and while that slot is full the input stalls.
// ----------------------------------------------------------------------------
`include "priority_interrupt_controller_assert.svh"

module priority_interrupt_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // offset[11:0], write_data[43:12], byte_count[46:44], line_number[52:47]
  input  logic [55:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[31:0], irq_valid[32], selected_irq[38:33]
  output logic [39:0] out_tdata,
  // status[0]
  output logic [0:0]  out_tuser
);
  import pic_pkg::*;

  logic [NUM_LINES:0] chain_vld;
  tok_t               chain_tok [NUM_LINES+1];
  ctrl_sts_t          sts;

  // decode, sequencing and result collection
  pic_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .launch_vld_o (chain_vld[0]),
    .launch_tok_o (chain_tok[0]),
    .exit_vld_i   (chain_vld[NUM_LINES]),
    .exit_tok_i   (chain_tok[NUM_LINES]),
    .sts_o        (sts)
  );

  // one cell per interrupt line
  for (genvar i = 0; i < NUM_LINES; i++) begin : g_cell
    pic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (LINE_W'(i)),
      .tok_vld_i (chain_vld[i]),
      .tok_i     (chain_tok[i]),
      .tok_vld_o (chain_vld[i+1]),
      .tok_o     (chain_tok[i+1])
    );
  end

  // checks
  `PIC_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, sts.busy, "accept did not start chain")
  `PIC_ASSERT_SAME(a_exit_busy, chain_vld[NUM_LINES], sts.busy, "token left chain while idle")
  `PIC_ASSERT_SAME(a_hold_out, sts.hold_v, out_tvalid, "hold slot full with output empty")

endmodule

// ===== test/pic_report_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pic_report_checker
// watches both streams of the interrupt controller, keeps its own copy of the
// enable, pending and priority state, predicts the report of every accepted
// transaction and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module pic_report_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // offset[11:0], write_data[43:12], byte_count[46:44], line_number[52:47]
  input  logic [55:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // read_data[31:0], irq_valid[32], selected_irq[38:33]
  input  logic [39:0] out_tdata,
  // status[0]
  input  logic [0:0]  out_tuser,
  output int          fail_count,
  output int          outstanding
);
  import pic_pkg::*;

  // bus map windows, first and last starting offset
  localparam logic [11:0] EN_RD_LO   = 12'h000;
  localparam logic [11:0] EN_RD_HI   = 12'h01C;
  localparam logic [11:0] PEND_RD_LO = 12'h020;
  localparam logic [11:0] PEND_RD_HI = 12'h03C;
  localparam logic [11:0] EN_SET_LO  = 12'h100;
  localparam logic [11:0] EN_SET_HI  = 12'h11C;
  localparam logic [11:0] EN_CLR_LO  = 12'h180;
  localparam logic [11:0] EN_CLR_HI  = 12'h19C;
  localparam logic [11:0] PD_SET_LO  = 12'h200;
  localparam logic [11:0] PD_SET_HI  = 12'h21C;
  localparam logic [11:0] PD_CLR_LO  = 12'h280;
  localparam logic [11:0] PD_CLR_HI  = 12'h29C;
  localparam logic [11:0] PRIO_LO    = 12'h400;
  localparam logic [11:0] PRIO_HI    = 12'h43C;

  localparam int         WORDS     = NUM_LINES / 32;
  localparam logic [7:0] PRIO_MASK = 8'((1 << PRIO_W) - 1);

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
    logic        irq_valid;
    logic [5:0]  selected_irq;
  } irq_report_t;

  // shadow controller state
  logic [31:0] en_bits   [WORDS];
  logic [31:0] pend_bits [WORDS];
  logic [7:0]  prio_bytes[NUM_LINES];

  irq_report_t expected_reports[$];
  irq_report_t got, want;
  logic        bad;

  function automatic logic in_window(input logic [11:0] off, input logic [11:0] lo,
                                     input logic [11:0] hi);
    return (off >= lo) && (off <= hi);
  endfunction

  // apply one operation to the shadow state and work out its report
  function automatic irq_report_t predict_report(input logic [1:0] op,
                                                 input logic [11:0] off,
                                                 input logic [31:0] wdata,
                                                 input logic [2:0] cnt_in,
                                                 input logic [5:0] line);
    irq_report_t r;
    int          cnt;
    int          w;
    int          first;
    logic [31:0] mask;
    logic [31:0] data;
    logic        found;
    logic [7:0]  best_p;
    int          best;
    r     = '0;
    cnt   = (cnt_in > 3'd4) ? 4 : int'(cnt_in);
    mask  = (cnt >= 4) ? 32'hFFFF_FFFF : ((32'h1 << (cnt * 8)) - 32'h1);
    data  = wdata & mask;
    first = int'(off) - int'(PRIO_LO);

    // bus access or line event
    if (op == OP_READ) begin
      if (in_window(off, EN_RD_LO, EN_RD_HI)) begin
        w = int'(off) >> 2;
        r.read_data = (w < WORDS) ? (en_bits[w] & mask) : 32'h0;
      end else if (in_window(off, PEND_RD_LO, PEND_RD_HI)) begin
        w = (int'(off) - int'(PEND_RD_LO)) >> 2;
        r.read_data = (w < WORDS) ? (pend_bits[w] & mask) : 32'h0;
      end else if (in_window(off, PRIO_LO, PRIO_HI)) begin
        for (int k = 0; k < cnt; k++)
          if (first + k < NUM_LINES)
            r.read_data |= 32'(prio_bytes[first + k]) << (8 * k);
      end else begin
        r.status = 1'b1;
      end
    end else if (op == OP_WRITE) begin
      if (in_window(off, EN_SET_LO, EN_SET_HI)) begin
        w = (int'(off) - int'(EN_SET_LO)) >> 2;
        if (w < WORDS) en_bits[w] |= data;
      end else if (in_window(off, EN_CLR_LO, EN_CLR_HI)) begin
        w = (int'(off) - int'(EN_CLR_LO)) >> 2;
        if (w < WORDS) en_bits[w] &= ~data;
      end else if (in_window(off, PD_SET_LO, PD_SET_HI)) begin
        w = (int'(off) - int'(PD_SET_LO)) >> 2;
        if (w < WORDS) pend_bits[w] |= data;
      end else if (in_window(off, PD_CLR_LO, PD_CLR_HI)) begin
        w = (int'(off) - int'(PD_CLR_LO)) >> 2;
        if (w < WORDS) pend_bits[w] &= ~data;
      end else if (in_window(off, PRIO_LO, PRIO_HI)) begin
        for (int k = 0; k < cnt; k++)
          if (first + k < NUM_LINES)
            prio_bytes[first + k] = 8'(data >> (8 * k)) & PRIO_MASK;
      end else begin
        r.status = 1'b1;
      end
    end else if (int'(line) < NUM_LINES) begin
      if (op == OP_RAISE) pend_bits[line >> 5][line[4:0]] = 1'b1;
      else                pend_bits[line >> 5][line[4:0]] = 1'b0;
    end

    // lowest priority value among enabled pending lines, lowest index on tie
    found  = 1'b0;
    best   = 0;
    best_p = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (en_bits[i >> 5][i % 32] && pend_bits[i >> 5][i % 32]) begin
        if (!found || prio_bytes[i] < best_p) begin
          found  = 1'b1;
          best   = i;
          best_p = prio_bytes[i];
        end
      end
    end
    r.irq_valid    = found;
    r.selected_irq = found ? 6'(best) : 6'd0;
    return r;
  endfunction

  // compare results, then record new transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORDS; i++) begin
        en_bits[i]   = '0;
        pend_bits[i] = '0;
      end
      for (int i = 0; i < NUM_LINES; i++) prio_bytes[i] = '0;
      expected_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_data    = out_tdata[31:0];
        got.irq_valid    = out_tdata[32];
        got.selected_irq = out_tdata[38:33];
        got.status       = out_tuser[0];
        if (expected_reports.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: rd=%h st=%0d irq=%0d sel=%0d",
                     got.read_data, got.status, got.irq_valid, got.selected_irq);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          bad  = (got.read_data !== want.read_data) || (got.status !== want.status) ||
                 (got.irq_valid !== want.irq_valid) ||
                 (got.selected_irq !== want.selected_irq);
          if (bad) begin
            if (fail_count < 10)
              $display({"mismatch: exp rd=%h st=%0d irq=%0d sel=%0d,",
                        " got rd=%h st=%0d irq=%0d sel=%0d"},
                       want.read_data, want.status, want.irq_valid, want.selected_irq,
                       got.read_data, got.status, got.irq_valid, got.selected_irq);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_reports.push_back(predict_report(in_tuser, in_tdata[11:0], in_tdata[43:12],
                                                  in_tdata[46:44], in_tdata[52:47]));
    end
    outstanding = expected_reports.size();
  end

endmodule

// ===== test/tb_priority_interrupt_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_interrupt_controller
// drives bus reads, bus writes and line raise/clear transactions into the
// controller with random gaps and output stalls; the report checker beside
// the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_priority_interrupt_controller;
  import pic_pkg::*;

  // window bases of the bus map
  localparam logic [11:0] OFF_EN_RD   = 12'h000;
  localparam logic [11:0] OFF_PEND_RD = 12'h020;
  localparam logic [11:0] OFF_EN_SET  = 12'h100;
  localparam logic [11:0] OFF_EN_CLR  = 12'h180;
  localparam logic [11:0] OFF_PD_SET  = 12'h200;
  localparam logic [11:0] OFF_PD_CLR  = 12'h280;
  localparam logic [11:0] OFF_PRIO    = 12'h400;

  localparam int RANDOM_ITEMS = 1000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  int          fail_count;
  int          outstanding;
  logic        no_idle;

  priority_interrupt_controller u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pic_report_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // one transaction on the input stream, then an optional gap
  task automatic issue(input logic [1:0] op, input logic [11:0] off,
                       input logic [31:0] wdata, input logic [2:0] cnt,
                       input logic [5:0] line);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, line, cnt, wdata, off};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // random transaction, biased toward mapped windows and small sizes
  task automatic issue_random();
    logic [1:0]  op;
    logic [11:0] base;
    logic [11:0] off;
    logic [31:0] wdata;
    logic [2:0]  cnt;
    int          r;
    r  = $urandom_range(0, 99);
    op = (r < 25) ? OP_READ : (r < 55) ? OP_WRITE : (r < 85) ? OP_RAISE : OP_CLEAR;
    if (op == OP_READ && $urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 2))
        0:       base = OFF_EN_RD;
        1:       base = OFF_PEND_RD;
        default: base = OFF_PRIO;
      endcase
    end else begin
      case ($urandom_range(0, 6))
        0:       base = OFF_EN_RD;
        1:       base = OFF_PEND_RD;
        2:       base = OFF_EN_SET;
        3:       base = OFF_EN_CLR;
        4:       base = OFF_PD_SET;
        5:       base = OFF_PD_CLR;
        default: base = OFF_PRIO;
      endcase
    end
    if (base == OFF_PRIO || $urandom_range(0, 9) < 3) off = base + 12'($urandom_range(0, 63));
    else                                              off = base + 12'($urandom_range(0, 7));
    if ($urandom_range(0, 19) == 0) off = 12'($urandom);
    cnt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    // small priority values give plenty of ties
    if (base == OFF_PRIO && $urandom_range(0, 9) < 6)
      wdata = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
               8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
    else
      wdata = $urandom;
    issue(op, off, wdata, cnt, 6'($urandom_range(0, 63)));
  endtask

  // output back-pressure: bursts of ready with random stalls
  initial begin
    int run;
    int gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_READ;
    no_idle   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, ties, windows, alignment and size corners
    issue(OP_READ,  OFF_EN_RD,          32'hFFFF_FFFF, 3'd4, 6'd0);
    issue(OP_WRITE, OFF_EN_SET,         32'hFFFF_FFFF, 3'd4, 6'd0);
    issue(OP_WRITE, OFF_EN_SET + 12'h4, 32'hFFFF_FFFF, 3'd4, 6'd0);
    issue(OP_RAISE, 12'h000,            32'h0,         3'd0, 6'd63);
    issue(OP_RAISE, 12'hFFF,            32'h0,         3'd7, 6'd0);
    issue(OP_WRITE, OFF_PRIO,           32'h0505_0505, 3'd4, 6'd0);
    issue(OP_WRITE, OFF_PRIO + 12'h3C,  32'hFF02_0304, 3'd4, 6'd0);
    issue(OP_READ,  OFF_PRIO + 12'h3D,  32'h0,         3'd4, 6'd0);
    issue(OP_READ,  OFF_PRIO + 12'h3A,  32'h0,         3'd4, 6'd0);
    issue(OP_READ,  OFF_EN_RD + 12'h7,  32'h0,         3'd2, 6'd0);
    issue(OP_READ,  OFF_EN_RD + 12'h1C, 32'h0,         3'd4, 6'd0);
    issue(OP_READ,  OFF_PEND_RD,        32'h0,         3'd0, 6'd0);
    issue(OP_READ,  OFF_PEND_RD + 12'h4, 32'h0,        3'd7, 6'd0);
    issue(OP_WRITE, OFF_PD_SET + 12'h1C, 32'hFFFF_FFFF, 3'd4, 6'd0);
    issue(OP_WRITE, OFF_EN_CLR,         32'h0000_0001, 3'd1, 6'd0);
    issue(OP_WRITE, OFF_PD_SET,         32'hAAAA_5555, 3'd2, 6'd0);
    issue(OP_WRITE, OFF_PD_CLR,         32'h0000_FFFF, 3'd5, 6'd0);
    issue(OP_CLEAR, 12'h000,            32'h0,         3'd0, 6'd63);
    issue(OP_WRITE, 12'h300,            32'hFFFF_FFFF, 3'd4, 6'd0);
    issue(OP_READ,  12'hFFF,            32'h0,         3'd4, 6'd0);
    issue(OP_WRITE, OFF_PRIO + 12'h4,   32'h0101_0101, 3'd0, 6'd0);
    issue(OP_RAISE, 12'h000,            32'h0,         3'd0, 6'd32);
    issue(OP_WRITE, OFF_PD_CLR + 12'h4, 32'hFFFF_FFFF, 3'd4, 6'd0);
    issue(OP_WRITE, OFF_PD_CLR,         32'hFFFF_FFFF, 3'd4, 6'd0);
    issue(OP_WRITE, OFF_EN_CLR + 12'h4, 32'hFFFF_FFFF, 3'd4, 6'd0);
    drain();

    // random traffic, with stretches of back-to-back transactions
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain();
      no_idle <= ((n / 100) % 4 == 1);
      issue_random();
    end

    // wait out the last results
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pic_pkg.sv
hw/rtl/pic_cell.sv
hw/rtl/pic_ctrl.sv
hw/rtl/priority_interrupt_controller.sv
test/pic_report_checker.sv
test/tb_priority_interrupt_controller.sv
